[rtl/msar_pkg.sv]
// ----------------------------------------------------------------------------
// msar_pkg
// Types and constants shared by the proxy SAR reassembler modules.
// ----------------------------------------------------------------------------
`default_nettype none

package msar_pkg;

	// Upper bound of the reassembly store; store addresses and fill counts are
	// sized for it whatever depth the top level selects.
	localparam int unsigned STORE_MAX  = 64;
	localparam int unsigned ADDR_W     = 6;
	localparam int unsigned FILL_W     = 7;
	localparam int unsigned CFG_DATA_W = 8;

	localparam int unsigned CMDQ_DEPTH = 4;
	localparam int unsigned CMDQ_AW    = 2;

	// SAR field of the header byte.
	localparam logic [1:0] SAR_COMPLETE = 2'h0;
	localparam logic [1:0] SAR_FIRST    = 2'h1;
	localparam logic [1:0] SAR_CONT     = 2'h2;
	localparam logic [1:0] SAR_LAST     = 2'h3;

	// Payload index saturates here: only the first two payload bytes matter.
	localparam logic [1:0] PIDX_SAT = 2'h2;

	localparam logic       KIND_NET_BYTE   = 1'b0;
	localparam logic       KIND_FILTER_UPD = 1'b1;

	localparam logic       RST_FORWARD_ENABLE    = 1'b1;
	localparam logic [5:0] RST_NET_PDU_TYPE      = 6'h00;
	localparam logic [5:0] RST_CONFIG_PDU_TYPE   = 6'h02;
	localparam logic [7:0] RST_SET_FILTER_OPCODE = 8'h00;

	typedef enum logic [1:0] {
		CFG_FORWARD_ENABLE,
		CFG_NET_PDU_TYPE,
		CFG_CONFIG_PDU_TYPE,
		CFG_SET_FILTER_OPCODE
	} cfg_idx_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_of_write;
		logic       last_of_write;
	} in_item_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] out_byte;
		logic       out_last;
		logic [7:0] cur_filter;
	} out_item_t;

	// Command passed from the classifier to the executor.
	typedef struct packed {
		logic              wr;
		logic [ADDR_W-1:0] wr_addr;
		logic [7:0]        data;
		logic              emit;
		logic              kind;
		logic              last;
		logic              flush;
		logic [FILL_W-1:0] count;
		logic [7:0]        filter;
	} cmd_t;

	typedef enum logic {
		BK_IDLE,
		BK_DRAIN
	} back_state_t;

endpackage

`default_nettype wire

[rtl/msar_front.sv]
// ----------------------------------------------------------------------------
// msar_front
// Accepts proxy PDU bytes, tracks the header state and the filter type, and
// turns each item into at most one command for the executor.
// ----------------------------------------------------------------------------
`default_nettype none

module msar_front import msar_pkg::*; #(
	parameter int unsigned STORE_DEPTH = 64
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire cfg_idx_t              cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire in_item_t              in_item,
	output logic                       cmd_push,
	output cmd_t                       cmd,
	input  wire logic                  cmd_full
);

	localparam logic [FILL_W-1:0] DEPTH_C = FILL_W'(STORE_DEPTH);

	logic              fwd_en_q;
	logic [5:0]        net_type_q;
	logic [5:0]        cfg_type_q;
	logic [7:0]        set_op_q;

	logic [1:0]        seg_q, seg_nx;
	logic [5:0]        kind_q, kind_nx;
	logic [1:0]        pidx_q, pidx_nx;
	logic [7:0]        op_q, op_nx;
	logic [7:0]        filt_q, filt_nx;
	logic [FILL_W-1:0] fill_q, fill_nx;
	logic              accept;
	cmd_t              cmd_c;
	logic [7:0]        b;

	assign in_stall = cmd_full;
	assign accept   = in_valid && !cmd_full;
	assign b        = in_item.data_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_en_q   <= RST_FORWARD_ENABLE;
			net_type_q <= RST_NET_PDU_TYPE;
			cfg_type_q <= RST_CONFIG_PDU_TYPE;
			set_op_q   <= RST_SET_FILTER_OPCODE;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FORWARD_ENABLE:    fwd_en_q   <= cfg_wdata[0];
				CFG_NET_PDU_TYPE:      net_type_q <= cfg_wdata[5:0];
				CFG_CONFIG_PDU_TYPE:   cfg_type_q <= cfg_wdata[5:0];
				CFG_SET_FILTER_OPCODE: set_op_q   <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		seg_nx  = seg_q;
		kind_nx = kind_q;
		pidx_nx = pidx_q;
		op_nx   = op_q;
		filt_nx = filt_q;
		fill_nx = fill_q;
		cmd_c   = '0;

		if (in_item.first_of_write) begin
			seg_nx  = b[7:6];
			kind_nx = b[5:0];
			pidx_nx = '0;
			op_nx   = '0;
			if (seg_nx inside {SAR_COMPLETE, SAR_FIRST}) begin
				fill_nx = '0;
			end
		end else begin
			if (pidx_q != PIDX_SAT) begin
				pidx_nx = 2'(pidx_q + 2'd1);
			end
			if (seg_q == SAR_COMPLETE) begin
				if (kind_q == net_type_q) begin
					if (fwd_en_q) begin
						cmd_c.emit = 1'b1;
						cmd_c.kind = KIND_NET_BYTE;
						cmd_c.data = b;
						cmd_c.last = in_item.last_of_write;
					end
				end else if (kind_q == cfg_type_q) begin
					if (pidx_q == 2'd0) begin
						op_nx = b;
					end else if (pidx_q == 2'd1 && op_q == set_op_q) begin
						filt_nx    = b;
						cmd_c.emit = 1'b1;
						cmd_c.kind = KIND_FILTER_UPD;
					end
				end
			end else if (fill_q < DEPTH_C) begin
				cmd_c.wr      = 1'b1;
				cmd_c.wr_addr = fill_q[ADDR_W-1:0];
				cmd_c.data    = b;
				fill_nx       = FILL_W'(fill_q + 7'd1);
			end
		end

		// The end of a last-segment write hands the whole buffer over and
		// clears the fill whether or not anything is emitted.
		if (in_item.last_of_write && seg_nx == SAR_LAST) begin
			if (fill_nx != '0 && fwd_en_q && kind_nx == net_type_q) begin
				cmd_c.flush = 1'b1;
				cmd_c.count = fill_nx;
			end
			fill_nx = '0;
		end

		cmd_c.filter = filt_nx;
	end

	assign cmd      = cmd_c;
	assign cmd_push = accept && (cmd_c.wr || cmd_c.emit || cmd_c.flush);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q  <= SAR_COMPLETE;
			kind_q <= '0;
			pidx_q <= '0;
			op_q   <= '0;
			filt_q <= '0;
			fill_q <= '0;
		end else if (accept) begin
			seg_q  <= seg_nx;
			kind_q <= kind_nx;
			pidx_q <= pidx_nx;
			op_q   <= op_nx;
			filt_q <= filt_nx;
			fill_q <= fill_nx;
		end
	end

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= DEPTH_C)
		else $error("reassembly fill exceeds store depth");

	a_wr_addr: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push && cmd.wr |-> {1'b0, cmd.wr_addr} < DEPTH_C)
		else $error("store write outside the store");

	a_flush_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push && cmd.flush |-> cmd.count != '0 && cmd.count <= DEPTH_C && !cmd.emit)
		else $error("flush command with a bad count");
`endif

endmodule

`default_nettype wire

[rtl/msar_cmd_fifo.sv]
// ----------------------------------------------------------------------------
// msar_cmd_fifo
// Short command queue between the classifier and the executor.
// ----------------------------------------------------------------------------
`default_nettype none

module msar_cmd_fifo import msar_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_data,
	output logic      full,
	input  wire logic pop,
	output cmd_t      head,
	output logic      empty
);

	cmd_t               ents_q [CMDQ_DEPTH];
	logic [CMDQ_AW-1:0] wr_ptr_q;
	logic [CMDQ_AW-1:0] rd_ptr_q;
	logic [CMDQ_AW:0]   cnt_q;

	assign full  = cnt_q == (CMDQ_AW+1)'(CMDQ_DEPTH);
	assign empty = cnt_q == '0;
	assign head  = ents_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ents_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= CMDQ_AW'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= CMDQ_AW'(rd_ptr_q + 1'b1);
			end
			if (push && !pop) begin
				cnt_q <= (CMDQ_AW+1)'(cnt_q + 1'b1);
			end else if (pop && !push) begin
				cnt_q <= (CMDQ_AW+1)'(cnt_q - 1'b1);
			end
		end
	end

`ifndef SYNTHESIS
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("command queue popped while empty");
`endif

endmodule

`default_nettype wire

[rtl/msar_back.sv]
// ----------------------------------------------------------------------------
// msar_back
// Executes commands: writes the reassembly store, passes single results on,
// and on a flush drains the store one byte per cycle unless the output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module msar_back import msar_pkg::*; #(
	parameter int unsigned STORE_DEPTH = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_empty,
	input  wire cmd_t cmd_head,
	output logic      cmd_pop,
	output logic      out_valid,
	input  wire logic out_stall,
	output out_item_t out_item
);

	localparam int unsigned AW = $clog2(STORE_DEPTH);

	logic [7:0]        mem [STORE_DEPTH];
	logic [7:0]        mem_rd_q;

	back_state_t       state_q, state_nx;
	logic [FILL_W-1:0] drain_idx_q;
	logic [FILL_W-1:0] drain_cnt_q;
	logic [7:0]        drain_filt_q;
	logic              drain_last;
	logic              rd_en;

	logic              valid_s1;
	logic              from_mem_s1;
	logic [7:0]        byte_s1;
	logic              kind_s1;
	logic              last_s1;
	logic [7:0]        filt_s1;

	logic              out_valid_q;
	out_item_t         out_q;
	logic              adv_out;
	logic              s1_free;
	logic              s1_load;

	assign adv_out    = !out_valid_q || !out_stall;
	assign s1_free    = !valid_s1 || adv_out;
	assign drain_last = FILL_W'(drain_idx_q + 7'd1) == drain_cnt_q;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			BK_IDLE: begin
				if (cmd_pop && cmd_head.flush) begin
					state_nx = BK_DRAIN;
				end
			end
			BK_DRAIN: begin
				if (rd_en && drain_last) begin
					state_nx = BK_IDLE;
				end
			end
			default: state_nx = BK_IDLE;
		endcase
	end

	// A write-only or flush command needs no room in the result stage.
	always_comb begin
		cmd_pop = 1'b0;
		rd_en   = 1'b0;
		case (state_q)
			BK_IDLE:  cmd_pop = !cmd_empty && (s1_free || !cmd_head.emit);
			BK_DRAIN: rd_en   = s1_free;
			default: ;
		endcase
	end

	assign s1_load = rd_en || (cmd_pop && cmd_head.emit);

	always_ff @(posedge clk) begin
		if (cmd_pop && cmd_head.wr) begin
			mem[cmd_head.wr_addr[AW-1:0]] <= cmd_head.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			mem_rd_q <= mem[drain_idx_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			drain_idx_q <= '0;
			drain_cnt_q <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd_pop && cmd_head.flush) begin
				drain_idx_q <= '0;
				drain_cnt_q <= cmd_head.count;
			end else if (rd_en) begin
				drain_idx_q <= FILL_W'(drain_idx_q + 7'd1);
			end
			if (s1_load) begin
				valid_s1 <= 1'b1;
			end else if (adv_out) begin
				valid_s1 <= 1'b0;
			end
			if (adv_out) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop && cmd_head.flush) begin
			drain_filt_q <= cmd_head.filter;
		end
		if (rd_en) begin
			from_mem_s1 <= 1'b1;
			kind_s1     <= KIND_NET_BYTE;
			last_s1     <= drain_last;
			filt_s1     <= drain_filt_q;
		end else if (cmd_pop && cmd_head.emit) begin
			from_mem_s1 <= 1'b0;
			byte_s1     <= cmd_head.data;
			kind_s1     <= cmd_head.kind;
			last_s1     <= cmd_head.last;
			filt_s1     <= cmd_head.filter;
		end
		if (adv_out && valid_s1) begin
			out_q.kind       <= kind_s1;
			out_q.out_byte   <= from_mem_s1 ? mem_rd_q : byte_s1;
			out_q.out_last   <= last_s1;
			out_q.cur_filter <= filt_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

`ifndef SYNTHESIS
	a_drain_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_DRAIN |-> drain_idx_q < drain_cnt_q)
		else $error("drain index ran past the flush count");

	a_read_lands: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |=> valid_s1 && from_mem_s1 && kind_s1 == KIND_NET_BYTE)
		else $error("store read did not reach the result stage");
`endif

endmodule

`default_nettype wire

[rtl/mesh_proxy_sar_reassembler.sv]
// ----------------------------------------------------------------------------
// mesh_proxy_sar_reassembler
// Proxy PDU receiver: classifies header and payload bytes, reassembles
// segmented network PDUs and tracks the proxy filter type.
//
//   Channel   Direction  Handshake          Payload
//   in        input      in_valid/in_stall  in_item   (in_item_t)
//   out       output     out_valid/out_stall out_item (out_item_t)
//   cfg       input      cfg_we             cfg_index, cfg_wdata
//
// One input byte is taken per cycle while the command queue has room.
// A flush drains the reassembly store at one byte per cycle, while the output
// is not stalled, through a registered memory read; the executor takes no new
// command until the drain is done, and input stalls once the four-entry queue
// is full. Results leave through an output register.
// Reset is asynchronous and active low; the store needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module mesh_proxy_sar_reassembler import msar_pkg::*; #(
	parameter int unsigned STORE_DEPTH = 64
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire cfg_idx_t              cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire in_item_t              in_item,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output out_item_t                  out_item
);

	logic cmd_push;
	cmd_t cmd_in;
	logic cmd_full;
	logic cmd_pop;
	cmd_t cmd_head;
	logic cmd_empty;

	msar_front #(
		.STORE_DEPTH(STORE_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.cmd_push (cmd_push),
		.cmd      (cmd_in),
		.cmd_full (cmd_full)
	);

	msar_cmd_fifo u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (cmd_push),
		.push_data(cmd_in),
		.full     (cmd_full),
		.pop      (cmd_pop),
		.head     (cmd_head),
		.empty    (cmd_empty)
	);

	msar_back #(
		.STORE_DEPTH(STORE_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_empty(cmd_empty),
		.cmd_head (cmd_head),
		.cmd_pop  (cmd_pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item)
	);

endmodule

`default_nettype wire

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Testbench for the proxy PDU SAR reassembler. Byte items of proxy writes are
// driven through the valid/stall input channel and each one is run through a
// behavioural model of the receiver, which queues the results it should
// produce. Every result taken from the output channel is checked field by
// field against the oldest queued result. Directed writes cover streaming,
// filter updates, segmentation and the corner cases; random writes follow
// under several register settings and idling patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	import msar_pkg::*;

	localparam int unsigned DEPTH       = 64;
	localparam int          TAIL_CYCLES = 16;
	localparam int          CYCLE_LIMIT = 300000;

	logic      clk;
	logic      arst_n    = 1'b0;
	logic      cfg_we    = 1'b0;
	cfg_idx_t  cfg_index = CFG_FORWARD_ENABLE;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic      in_valid  = 1'b0;
	logic      in_stall;
	in_item_t  in_item   = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_item_t out_item;

	// Register copies and receiver state of the model.
	logic       fwd_en;
	logic [5:0] net_type;
	logic [5:0] cfg_type;
	logic [7:0] filt_opcode;
	logic [7:0] reasm_buf [0:DEPTH-1];
	int         fill;
	logic [1:0] sar_mode;
	logic [5:0] hdr_type;
	logic [15:0] pay_idx;
	logic [7:0] opcode_byte;
	logic [7:0] filter_now;

	out_item_t  expected_q [$];
	logic [7:0] body [0:31];

	int send_pct;
	int recv_pct;
	int errors       = 0;
	int items_sent   = 0;
	int results_seen = 0;
	int filter_seen  = 0;
	int cycle_count  = 0;

	mesh_proxy_sar_reassembler #(
		.STORE_DEPTH(DEPTH)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
				expected_q.size());
			$display("tb failed");
			$finish;
		end
	end

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_pct);
	end

	function automatic void queue_result(input logic kind, input logic [7:0] b,
		input logic last_flag);
		out_item_t r;
		r.kind       = kind;
		r.out_byte   = b;
		r.out_last   = last_flag;
		r.cur_filter = filter_now;
		expected_q.push_back(r);
	endfunction

	task automatic predict_item(input in_item_t it);
		logic [15:0] idx;
		if (it.first_of_write) begin
			sar_mode    = it.data_byte[7:6];
			hdr_type    = it.data_byte[5:0];
			pay_idx     = '0;
			opcode_byte = '0;
			if (sar_mode == SAR_COMPLETE || sar_mode == SAR_FIRST)
				fill = 0;
		end else begin
			idx = pay_idx;
			if (pay_idx != 16'hFFFF)
				pay_idx++;
			if (sar_mode == SAR_COMPLETE) begin
				// Network handling takes precedence when both type codes match.
				if (hdr_type == net_type) begin
					if (fwd_en)
						queue_result(KIND_NET_BYTE, it.data_byte, it.last_of_write);
				end else if (hdr_type == cfg_type) begin
					if (idx == 0) begin
						opcode_byte = it.data_byte;
					end else if (idx == 1 && opcode_byte == filt_opcode) begin
						filter_now = it.data_byte;
						queue_result(KIND_FILTER_UPD, 8'h00, 1'b0);
					end
				end
			end else if (fill < DEPTH) begin
				reasm_buf[fill] = it.data_byte;
				fill++;
			end
		end
		if (it.last_of_write && sar_mode == SAR_LAST) begin
			if (fill > 0 && fwd_en && hdr_type == net_type)
				for (int i = 0; i < fill; i++)
					queue_result(KIND_NET_BYTE, reasm_buf[i], i + 1 == fill);
			fill = 0;
		end
	endtask

	function automatic void check_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %02h, actual %02h", $time, name, want, got);
		end
	endfunction

	always @(posedge clk) begin : result_check
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual %0d/%02h/%0d/%02h",
					$time, out_item.kind, out_item.out_byte, out_item.out_last,
					out_item.cur_filter);
			end else begin
				want = expected_q.pop_front();
				check_field("kind", 8'(want.kind), 8'(out_item.kind));
				check_field("out_byte", want.out_byte, out_item.out_byte);
				check_field("out_last", 8'(want.out_last), 8'(out_item.out_last));
				check_field("cur_filter", want.cur_filter, out_item.cur_filter);
				results_seen++;
				if (want.kind == KIND_FILTER_UPD)
					filter_seen++;
			end
		end
	end

	task automatic send_item(input in_item_t it);
		@(negedge clk);
		while ($urandom_range(99) < send_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_item(it);
		items_sent++;
	endtask

	task automatic send_loose(input logic [7:0] b, input logic last_flag);
		in_item_t it;
		it.data_byte      = b;
		it.first_of_write = 1'b0;
		it.last_of_write  = last_flag;
		send_item(it);
	endtask

	// Header followed by len bytes taken from body; closed marks the last item.
	task automatic send_pdu(input logic [1:0] sar, input logic [5:0] ptype, input int len,
		input logic closed);
		in_item_t it;
		it.data_byte      = {sar, ptype};
		it.first_of_write = 1'b1;
		it.last_of_write  = closed && len == 0;
		send_item(it);
		for (int i = 0; i < len; i++)
			send_loose(body[i], closed && i == len - 1);
	endtask

	task automatic wait_drained;
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [7:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_FORWARD_ENABLE:    fwd_en      = val[0];
			CFG_NET_PDU_TYPE:      net_type    = val[5:0];
			CFG_CONFIG_PDU_TYPE:   cfg_type    = val[5:0];
			CFG_SET_FILTER_OPCODE: filt_opcode = val;
			default: ;
		endcase
	endtask

	task automatic set_config(input logic fwd, input logic [5:0] nt, input logic [5:0] ct,
		input logic [7:0] op);
		write_reg(CFG_FORWARD_ENABLE, {7'd0, fwd});
		write_reg(CFG_NET_PDU_TYPE, {2'd0, nt});
		write_reg(CFG_CONFIG_PDU_TYPE, {2'd0, ct});
		write_reg(CFG_SET_FILTER_OPCODE, op);
	endtask

	task automatic test_stream_and_filter;
		// Straight after reset the latest header counts as a complete network one.
		send_loose(8'hFF, 1'b1);
		send_pdu(SAR_COMPLETE, net_type, 0, 1'b1);
		body[0] = 8'h00;
		body[1] = 8'hFF;
		send_pdu(SAR_COMPLETE, net_type, 2, 1'b1);
		body[0] = filt_opcode;
		body[1] = 8'hA5;
		body[2] = 8'h11;
		send_pdu(SAR_COMPLETE, cfg_type, 3, 1'b1);
	endtask

	task automatic test_segmentation;
		// Only the last segment's type decides whether the buffer goes out.
		body[0] = 8'h12;
		send_pdu(SAR_FIRST, 6'h05, 1, 1'b1);
		body[0] = 8'h34;
		send_pdu(SAR_CONT, 6'h09, 1, 1'b1);
		body[0] = 8'h56;
		send_pdu(SAR_LAST, net_type, 1, 1'b1);
		body[0] = 8'h77;
		send_pdu(SAR_FIRST, net_type, 1, 1'b1);
		send_pdu(SAR_LAST, net_type, 0, 1'b1);
		send_loose(8'h99, 1'b1);
	endtask

	task automatic test_forward_disable;
		wait_drained();
		write_reg(CFG_FORWARD_ENABLE, 8'h00);
		body[0] = 8'h33;
		send_pdu(SAR_COMPLETE, net_type, 1, 1'b1);
		body[0] = 8'h01;
		send_pdu(SAR_FIRST, net_type, 1, 1'b1);
		send_pdu(SAR_LAST, net_type, 0, 1'b1);
		wait_drained();
		write_reg(CFG_FORWARD_ENABLE, 8'h01);
	endtask

	task automatic test_shared_type_code;
		wait_drained();
		set_config(1'b1, 6'h3F, 6'h3F, 8'hFF);
		body[0] = 8'hFF;
		body[1] = 8'h42;
		send_pdu(SAR_COMPLETE, net_type, 2, 1'b1);
		wait_drained();
		write_reg(CFG_CONFIG_PDU_TYPE, 8'h00);
		body[0] = 8'hFF;
		body[1] = 8'h00;
		send_pdu(SAR_COMPLETE, cfg_type, 2, 1'b1);
	endtask

	task automatic test_random_traffic(input int n_items, input int snd, input int rcv,
		input logic [5:0] nt, input logic [5:0] ct, input logic [7:0] op);
		int start;
		int sel;
		int len;
		int nseg;
		int seg_len;
		bit big;
		logic [1:0] seg_sar;
		logic [5:0] t;
		wait_drained();
		send_pct = snd;
		recv_pct = rcv;
		set_config(1'b1, nt, ct, op);
		start = items_sent;
		while (items_sent - start < n_items) begin
			sel = $urandom_range(99);
			for (int i = 0; i < 32; i++)
				body[i] = 8'($urandom_range(255));
			if (sel < 25) begin
				send_pdu(SAR_COMPLETE, nt, $urandom_range(6), 1'b1);
			end else if (sel < 40) begin
				if ($urandom_range(3) != 0)
					body[0] = op;
				send_pdu(SAR_COMPLETE, ct, $urandom_range(1, 4), 1'b1);
			end else if (sel < 70) begin
				// A few long sets run past the end of the store.
				big  = ($urandom_range(14) == 0);
				nseg = $urandom_range(2);
				for (int s = 0; s < nseg + 2; s++) begin
					seg_len = big ? $urandom_range(24, 30) : $urandom_range(5);
					for (int i = 0; i < seg_len; i++)
						body[i] = 8'($urandom_range(255));
					if (s == 0)
						seg_sar = SAR_FIRST;
					else if (s == nseg + 1)
						seg_sar = SAR_LAST;
					else
						seg_sar = SAR_CONT;
					t = ($urandom_range(3) != 0) ? nt : 6'($urandom_range(63));
					send_pdu(seg_sar, t, seg_len, 1'b1);
				end
			end else if (sel < 85) begin
				case ($urandom_range(3))
					0:       t = nt;
					1:       t = ct;
					default: t = 6'($urandom_range(63));
				endcase
				send_pdu(2'($urandom_range(3)), t, $urandom_range(4),
					$urandom_range(3) != 0);
			end else if (sel < 96) begin
				len = $urandom_range(1, 3);
				for (int i = 0; i < len; i++)
					send_loose(body[i], 1'($urandom_range(1)));
			end else begin
				// Hold off input until the output side has caught up.
				wait_drained();
			end
		end
	endtask

	task automatic sel_third_phase;
		logic [5:0] nt;
		nt = 6'($urandom_range(1, 62));
		test_random_traffic(40, 0, 0, nt, nt ^ 6'h2A, 8'($urandom_range(255)));
	endtask

	initial begin
		fwd_en      = RST_FORWARD_ENABLE;
		net_type    = RST_NET_PDU_TYPE;
		cfg_type    = RST_CONFIG_PDU_TYPE;
		filt_opcode = RST_SET_FILTER_OPCODE;
		fill        = 0;
		sar_mode    = SAR_COMPLETE;
		hdr_type    = '0;
		pay_idx     = '0;
		opcode_byte = '0;
		filter_now  = '0;
		send_pct    = 38;
		recv_pct    = 51;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_stream_and_filter();
		test_segmentation();
		test_forward_disable();
		test_shared_type_code();
		test_random_traffic(40, 38, 51, 6'h00, 6'h3F, 8'hFF);
		test_random_traffic(40, 51, 38, 6'h3F, 6'h00, 8'h00);
		sel_third_phase();
		wait_drained();

		$display("Covered %0d input items and %0d checked results, %0d of them filter updates,",
			items_sent, results_seen, filter_seen);
		$display("across several register settings with and without idling on either side.");
		if (errors == 0) begin
			$display("tb passed");
		end else begin
			$display("%0d mismatches", errors);
			$display("tb failed");
		end
		$finish;
	end

endmodule

`default_nettype wire

[sim.f]
rtl/msar_pkg.sv
rtl/msar_front.sv
rtl/msar_cmd_fifo.sv
rtl/msar_back.sv
rtl/mesh_proxy_sar_reassembler.sv
sim/tb.sv
